[hw/rtl/touch_debounce_region_dispatch_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the touch front end
// Shared property forms: same-cycle and next-cycle implication.
// ----------------------------------------------------------------------------
`ifndef TOUCH_DEBOUNCE_REGION_DISPATCH_TOP_ASSERT_SVH
`define TOUCH_DEBOUNCE_REGION_DISPATCH_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define TDRD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define TDRD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/tdrd_pkg.sv]
// ----------------------------------------------------------------------------
// tdrd_pkg
// Types and constants for the touch debounce and region dispatch block.
// ----------------------------------------------------------------------------
package tdrd_pkg;

   localparam int NUM_REGIONS_DEF = 16;
   localparam int COORD_W         = 16;
   localparam int TOUCH_W         = 13;
   localparam int IDX_W           = 4;
   localparam int TOTAL_W         = 5;
   localparam int CSR_W           = 16;
   localparam int TICK_W          = 32;
   localparam int SAMPLE_SHIFT    = 3;

   localparam logic [CSR_W-1:0] DEBOUNCE_RST = 16'd20;
   localparam logic [CSR_W-1:0] HOLDOFF_RST  = 16'd100;

   // register indexes
   localparam logic CSR_DEBOUNCE = 1'b0;
   localparam logic CSR_HOLDOFF  = 1'b1;

   // input item kinds
   localparam logic KIND_TICK     = 1'b0;
   localparam logic KIND_REGISTER = 1'b1;

   // result kinds and registration status
   localparam logic RESULT_HIT   = 1'b0;
   localparam logic RESULT_REPLY = 1'b1;
   localparam logic STATUS_STORED = 1'b0;
   localparam logic STATUS_FULL   = 1'b1;

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_IRQ      = 2'd1,
      PH_DEBOUNCE = 2'd2,
      PH_HOLDOFF  = 2'd3
   } phase_type;

   typedef enum logic {
      SEQ_IDLE = 1'b0,
      SEQ_SCAN = 1'b1
   } seq_type;

   typedef struct packed {
      logic               kind;
      logic               pen_irq;
      logic               pen_down;
      logic [COORD_W-1:0] x_sample;
      logic [COORD_W-1:0] y_sample;
      logic [COORD_W-1:0] region_x;
      logic [COORD_W-1:0] region_y;
      logic [COORD_W-1:0] region_width;
      logic [COORD_W-1:0] region_height;
      logic               region_notify;
   } req_type;

   typedef struct packed {
      logic               result_kind;
      logic [IDX_W-1:0]   region_index;
      logic [TOUCH_W-1:0] touch_x;
      logic [TOUCH_W-1:0] touch_y;
      logic               register_status;
      logic [TOTAL_W-1:0] region_total;
      logic               last;
   } rsp_type;

   // one region table entry as held in memory
   typedef struct packed {
      logic               enable;
      logic [COORD_W-1:0] rx;
      logic [COORD_W-1:0] ry;
      logic [COORD_W-1:0] rw;
      logic [COORD_W-1:0] rh;
   } entry_type;

endpackage

[hw/rtl/tdrd_ram.sv]
// ----------------------------------------------------------------------------
// tdrd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tdrd_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/touch_debounce_region_dispatch_top.sv]
// ----------------------------------------------------------------------------
// touch_debounce_region_dispatch_top
// Touch front end: interrupt debounce, holdoff and region hit dispatch.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions are taken on start while busy is low. A register
//   transaction writes one rectangle into the region memory unless the
//   table is full; its reply shows on rsp_valid in the next cycle. A tick
//   transaction (one millisecond) steps the touch phase machine in the
//   cycle it is taken; it gives no result except on the tick that ends the
//   debounce wait with the pen down. That tick starts a scan of the region
//   memory: one entry read per cycle through the single read port, so busy
//   stays high for the whole scan. Hits leave one per cycle at most, each
//   held until the next hit or the scan end so the final hit can carry
//   last; the final hit appears on the cycle busy falls.
//   Results are strobed for exactly one cycle; the receiver cannot stall.
//   Reset clears the phase machine, counters, region count and the CSRs
//   (debounce 20, holdoff 100). The region memory is not cleared: only
//   entries below the region count are ever read. CSR writes take effect
//   at the next edge and are expected only while the block is idle.
// ----------------------------------------------------------------------------
`include "touch_debounce_region_dispatch_top_assert.svh"

module touch_debounce_region_dispatch_top #(
   parameter int NUM_REGIONS = tdrd_pkg::NUM_REGIONS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  tdrd_pkg::req_type          req_data,
   output logic                       rsp_valid,
   output tdrd_pkg::rsp_type          rsp_data,
   input  logic                       csr_we,
   input  logic                       csr_index,
   input  logic [tdrd_pkg::CSR_W-1:0] csr_wdata
);
   import tdrd_pkg::*;

   localparam int AW = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
   localparam int CW = $clog2(NUM_REGIONS + 1);
   localparam int EW = $bits(entry_type);

   // transaction decode
   logic accept, tick_acc, reg_acc, full;

   // CSRs
   logic [CSR_W-1:0] debounce_ff, holdoff_ff;

   // touch phase state
   phase_type         phase_ff, phase_in;
   logic              irq_seen_ff, irq_in;
   logic [TICK_W-1:0] tick_count_ff, tick_in, mark_time_ff, mark_in;
   logic [TICK_W-1:0] tick_next, elapsed;
   logic              deb_done, hold_done, scan_go;

   // region table and scan sequencer
   logic [CW-1:0]      count_ff, count_in;
   seq_type            seq_ff, seq_in;
   logic [CW-1:0]      scan_idx_ff, scan_idx_in;
   logic               rd_vld_ff;
   logic [AW-1:0]      rd_idx_ff;
   logic               hold_vld_ff, hold_vld_in;
   logic [AW-1:0]      hold_idx_ff, hold_idx_in;
   logic [TOUCH_W-1:0] touch_x_ff, touch_y_ff;
   logic               scan_issue, scan_done, hit;

   // memory ports
   logic      wr_en;
   entry_type wr_entry, rd_entry;
   logic [EW-1:0] rd_word;

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic [COORD_W:0] px, py, rx_ext, ry_ext, x_end, y_end;

   assign accept   = start && !busy;
   assign tick_acc = accept && (req_data.kind == KIND_TICK);
   assign reg_acc  = accept && (req_data.kind == KIND_REGISTER);
   assign full     = (count_ff >= CW'(NUM_REGIONS));
   assign busy     = (seq_ff != SEQ_IDLE);

   // wait timing: elapsed ticks measured on the incremented tick count
   assign tick_next = tick_count_ff + TICK_W'(1);
   assign elapsed   = tick_next - mark_time_ff;
   assign deb_done  = (elapsed >= TICK_W'(debounce_ff));
   assign hold_done = (elapsed >= TICK_W'(holdoff_ff));

   // scan: one read issued per cycle, data checked the cycle after
   assign scan_issue = (seq_ff == SEQ_SCAN) && (scan_idx_ff < count_ff);
   assign scan_done  = (seq_ff == SEQ_SCAN) && !scan_issue && !rd_vld_ff;

   assign rd_entry = entry_type'(rd_word);
   assign px       = (COORD_W+1)'(touch_x_ff);
   assign py       = (COORD_W+1)'(touch_y_ff);
   assign rx_ext   = (COORD_W+1)'(rd_entry.rx);
   assign ry_ext   = (COORD_W+1)'(rd_entry.ry);
   assign x_end    = rx_ext + (COORD_W+1)'(rd_entry.rw);
   assign y_end    = ry_ext + (COORD_W+1)'(rd_entry.rh);
   // strict on the low edge, inclusive on the high edge
   assign hit = rd_vld_ff && rd_entry.enable &&
                (px > rx_ext) && (px <= x_end) &&
                (py > ry_ext) && (py <= y_end);

   // next state: touch phase machine, stepped once per tick transaction
   always_comb begin
      phase_in = phase_ff;
      irq_in   = irq_seen_ff;
      tick_in  = tick_count_ff;
      mark_in  = mark_time_ff;
      scan_go  = 1'b0;
      if (tick_acc) begin
         // latch the interrupt before stepping the phase
         irq_in  = irq_seen_ff || req_data.pen_irq;
         tick_in = tick_next;
         case (phase_ff)
            PH_IDLE: begin
               if (irq_in) begin
                  phase_in = PH_IRQ;
               end
            end
            PH_IRQ: begin
               mark_in  = tick_next;
               phase_in = PH_DEBOUNCE;
            end
            PH_DEBOUNCE: begin
               if (deb_done) begin
                  phase_in = PH_HOLDOFF;
                  mark_in  = tick_next;
                  // sample only when the pen is still down and regions exist
                  scan_go  = req_data.pen_down && (count_ff != '0);
               end
            end
            PH_HOLDOFF: begin
               if (hold_done) begin
                  phase_in = PH_IDLE;
                  irq_in   = 1'b0;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   // next state: scan sequencer
   always_comb begin
      case (seq_ff)
         SEQ_IDLE: seq_in = scan_go ? SEQ_SCAN : SEQ_IDLE;
         SEQ_SCAN: seq_in = scan_done ? SEQ_IDLE : SEQ_SCAN;
         default:  seq_in = SEQ_IDLE;
      endcase
   end

   // outputs: memory write, scan bookkeeping and result register
   always_comb begin
      wr_en             = reg_acc && !full;
      wr_entry.enable   = req_data.region_notify;
      wr_entry.rx       = req_data.region_x;
      wr_entry.ry       = req_data.region_y;
      wr_entry.rw       = req_data.region_width;
      wr_entry.rh       = req_data.region_height;
      count_in          = wr_en ? (count_ff + CW'(1)) : count_ff;

      scan_idx_in = scan_idx_ff;
      hold_vld_in = hold_vld_ff;
      hold_idx_in = hold_idx_ff;
      if (scan_go) begin
         scan_idx_in = '0;
         hold_vld_in = 1'b0;
      end else if (scan_issue) begin
         scan_idx_in = scan_idx_ff + CW'(1);
      end
      if (hit) begin
         hold_vld_in = 1'b1;
         hold_idx_in = rd_idx_ff;
      end

      rsp_valid_in = 1'b0;
      rsp_data_in  = '0;
      if (reg_acc) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.result_kind     = RESULT_REPLY;
         rsp_data_in.register_status = full ? STATUS_FULL : STATUS_STORED;
         rsp_data_in.region_total    = TOTAL_W'(count_in);
         rsp_data_in.last            = 1'b1;
      end else if (hold_vld_ff && (hit || scan_done)) begin
         // a newer hit displaces the held one; the scan end releases it as last
         rsp_valid_in              = 1'b1;
         rsp_data_in.result_kind   = RESULT_HIT;
         rsp_data_in.region_index  = IDX_W'(hold_idx_ff);
         rsp_data_in.touch_x       = touch_x_ff;
         rsp_data_in.touch_y       = touch_y_ff;
         rsp_data_in.last          = scan_done;
      end
   end

   tdrd_ram #(
      .WIDTH (EW),
      .DEPTH (NUM_REGIONS)
   ) u_region_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_entry),
      .rd_en   (scan_issue),
      .rd_addr (scan_idx_ff[AW-1:0]),
      .rd_data (rd_word)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= DEBOUNCE_RST;
         holdoff_ff    <= HOLDOFF_RST;
         phase_ff      <= PH_IDLE;
         irq_seen_ff   <= 1'b0;
         tick_count_ff <= '0;
         mark_time_ff  <= '0;
         count_ff      <= '0;
         seq_ff        <= SEQ_IDLE;
         scan_idx_ff   <= '0;
         rd_vld_ff     <= 1'b0;
         hold_vld_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we && (csr_index == CSR_DEBOUNCE)) begin
            debounce_ff <= csr_wdata;
         end
         if (csr_we && (csr_index == CSR_HOLDOFF)) begin
            holdoff_ff <= csr_wdata;
         end
         phase_ff      <= phase_in;
         irq_seen_ff   <= irq_in;
         tick_count_ff <= tick_in;
         mark_time_ff  <= mark_in;
         count_ff      <= count_in;
         seq_ff        <= seq_in;
         scan_idx_ff   <= scan_idx_in;
         rd_vld_ff     <= scan_issue;
         hold_vld_ff   <= hold_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff   <= scan_idx_ff[AW-1:0];
      hold_idx_ff <= hold_idx_in;
      rsp_data_ff <= rsp_data_in;
      if (scan_go) begin
         touch_x_ff <= TOUCH_W'(req_data.x_sample >> SAMPLE_SHIFT);
         touch_y_ff <= TOUCH_W'(req_data.y_sample >> SAMPLE_SHIFT);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `TDRD_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(NUM_REGIONS), "region count above table size")
   `TDRD_ASSERT_IMP(a_count_grows, clock, reset, !$past(reset), count_ff >= $past(count_ff), "region count decreased")
   `TDRD_ASSERT_IMP(a_hit_from_scan, clock, reset, rsp_valid_ff && (rsp_data_ff.result_kind == RESULT_HIT), $past(seq_ff == SEQ_SCAN), "hit result outside a scan")
   `TDRD_ASSERT_IMP(a_last_hit_ends, clock, reset, rsp_valid_ff && (rsp_data_ff.result_kind == RESULT_HIT) && rsp_data_ff.last, seq_ff == SEQ_IDLE, "final hit while scan still running")
   `TDRD_ASSERT_NXT(a_idle_no_read, clock, reset, seq_ff == SEQ_IDLE, seq_ff == SEQ_SCAN || !rd_vld_ff || $past(scan_issue), "read data pending outside a scan")

endmodule

[sim/touch_debounce_region_dispatch_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_debounce_region_dispatch_checker
// Watches the request, result and CSR ports of the touch front end. It keeps
// its own copy of the phase machine, the timing CSRs and the region table,
// works out the hits and registration replies for every accepted
// transaction, and compares each strobed result with the oldest one due.
// ----------------------------------------------------------------------------
module touch_debounce_region_dispatch_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  tdrd_pkg::req_type          req_data,
   input  logic                       rsp_valid,
   input  tdrd_pkg::rsp_type          rsp_data,
   input  logic                       csr_we,
   input  logic                       csr_index,
   input  logic [tdrd_pkg::CSR_W-1:0] csr_wdata,
   output int unsigned                mismatches,
   output int unsigned                outstanding,
   output int unsigned                hits_checked,
   output int unsigned                replies_checked,
   output int unsigned                full_replies
);
   import tdrd_pkg::*;

   localparam int PRINT_CAP = 100;

   logic [CSR_W-1:0]   debounce_ticks;
   logic [CSR_W-1:0]   holdoff_ticks;
   phase_type          phase;
   logic               irq_latched;
   logic [TICK_W-1:0]  tick_count;
   logic [TICK_W-1:0]  mark_tick;
   logic [TOTAL_W-1:0] region_count;
   entry_type          region_table [NUM_REGIONS_DEF];
   rsp_type            due_results [$];
   rsp_type            oldest;

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= PRINT_CAP)
         $display("%0t ns: mismatch: %s", $time, msg);
   endtask

   task automatic compare_result(input rsp_type got, input rsp_type want);
      if (got.result_kind !== want.result_kind)
         report_mismatch($sformatf("result_kind %0d, expected %0d",
                                   got.result_kind, want.result_kind));
      if (got.region_index !== want.region_index)
         report_mismatch($sformatf("region_index %0d, expected %0d",
                                   got.region_index, want.region_index));
      if (got.touch_x !== want.touch_x)
         report_mismatch($sformatf("touch_x %0d, expected %0d", got.touch_x, want.touch_x));
      if (got.touch_y !== want.touch_y)
         report_mismatch($sformatf("touch_y %0d, expected %0d", got.touch_y, want.touch_y));
      if (got.register_status !== want.register_status)
         report_mismatch($sformatf("register_status %0d, expected %0d",
                                   got.register_status, want.register_status));
      if (got.region_total !== want.region_total)
         report_mismatch($sformatf("region_total %0d, expected %0d",
                                   got.region_total, want.region_total));
      if (got.last !== want.last)
         report_mismatch($sformatf("last %0d, expected %0d", got.last, want.last));
   endtask

   // Advance the touch front end by one transaction and queue what it emits.
   task automatic step_front_end(input req_type item);
      rsp_type            reply;
      rsp_type            hits [$];
      logic [TOUCH_W-1:0] px;
      logic [TOUCH_W-1:0] py;
      logic [COORD_W:0]   right_edge;
      logic [COORD_W:0]   bottom_edge;
      logic [TICK_W-1:0]  elapsed;
      if (item.kind == KIND_REGISTER) begin
         reply = '0;
         reply.result_kind = RESULT_REPLY;
         reply.register_status = STATUS_FULL;
         if (region_count < NUM_REGIONS_DEF) begin
            region_table[region_count].enable = item.region_notify;
            region_table[region_count].rx = item.region_x;
            region_table[region_count].ry = item.region_y;
            region_table[region_count].rw = item.region_width;
            region_table[region_count].rh = item.region_height;
            region_count = region_count + 1'b1;
            reply.register_status = STATUS_STORED;
         end
         reply.region_total = region_count;
         reply.last = 1'b1;
         due_results.push_back(reply);
      end else begin
         if (item.pen_irq)
            irq_latched = 1'b1;
         tick_count = tick_count + 1'b1;
         elapsed = tick_count - mark_tick;
         case (phase)
            PH_IDLE: begin
               if (irq_latched)
                  phase = PH_IRQ;
            end
            PH_IRQ: begin
               mark_tick = tick_count;
               phase = PH_DEBOUNCE;
            end
            PH_DEBOUNCE: begin
               if (elapsed >= debounce_ticks) begin
                  phase = PH_HOLDOFF;
                  mark_tick = tick_count;
                  if (item.pen_down) begin
                     px = item.x_sample[COORD_W-1:SAMPLE_SHIFT];
                     py = item.y_sample[COORD_W-1:SAMPLE_SHIFT];
                     for (int i = 0; i < region_count; i++) begin
                        right_edge = region_table[i].rx + region_table[i].rw;
                        bottom_edge = region_table[i].ry + region_table[i].rh;
                        if (region_table[i].enable && px > region_table[i].rx &&
                            px <= right_edge && py > region_table[i].ry &&
                            py <= bottom_edge) begin
                           reply = '0;
                           reply.result_kind = RESULT_HIT;
                           reply.region_index = i[IDX_W-1:0];
                           reply.touch_x = px;
                           reply.touch_y = py;
                           hits.push_back(reply);
                        end
                     end
                     if (hits.size() > 0)
                        hits[hits.size()-1].last = 1'b1;
                     foreach (hits[k])
                        due_results.push_back(hits[k]);
                  end
               end
            end
            default: begin
               // an interrupt latched on the tick that ends the holdoff is dropped here
               if (elapsed >= holdoff_ticks) begin
                  phase = PH_IDLE;
                  irq_latched = 1'b0;
               end
            end
         endcase
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         debounce_ticks = DEBOUNCE_RST;
         holdoff_ticks = HOLDOFF_RST;
         phase = PH_IDLE;
         irq_latched = 1'b0;
         tick_count = '0;
         mark_tick = '0;
         region_count = '0;
         due_results.delete();
         mismatches = 0;
         hits_checked = 0;
         replies_checked = 0;
         full_replies = 0;
         outstanding <= 0;
      end else begin
         // results of earlier transactions come first, then the new one
         if (rsp_valid) begin
            if (due_results.size() == 0) begin
               report_mismatch($sformatf("result with nothing due: kind %0d index %0d",
                                         rsp_data.result_kind, rsp_data.region_index));
            end else begin
               oldest = due_results.pop_front();
               if (oldest.result_kind == RESULT_HIT) begin
                  hits_checked++;
               end else begin
                  replies_checked++;
                  if (oldest.register_status == STATUS_FULL)
                     full_replies++;
               end
               compare_result(rsp_data, oldest);
            end
         end
         if (start && !busy)
            step_front_end(req_data);
         if (csr_we) begin
            if (csr_index == CSR_DEBOUNCE)
               debounce_ticks = csr_wdata;
            else
               holdoff_ticks = csr_wdata;
         end
         outstanding <= due_results.size();
      end
   end

endmodule

[sim/touch_debounce_region_dispatch_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_debounce_region_dispatch_top_test
// Drives region registrations and millisecond ticks into the touch front end
// across several debounce and holdoff settings, from zero to full scale. A
// checker beside the block predicts and compares every result; this module
// only makes the stimulus, runs the watchdog and gives the verdict.
// ----------------------------------------------------------------------------
module touch_debounce_region_dispatch_top_test;
   import tdrd_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   // long enough for busy to fall after a full-table scan
   localparam int SETTLE_CYCLES  = NUM_REGIONS_DEF + 4;
   localparam int IDLE_PERCENT   = 19;

   logic             clock = 1'b0;
   logic             reset;
   logic             start;
   logic             busy;
   req_type          req_data;
   logic             rsp_valid;
   rsp_type          rsp_data;
   logic             csr_we;
   logic             csr_index;
   logic [CSR_W-1:0] csr_wdata;

   int unsigned      mismatches;
   int unsigned      outstanding;
   int unsigned      hits_checked;
   int unsigned      replies_checked;
   int unsigned      full_replies;
   int unsigned      accepted;
   int unsigned      settings_run;
   int unsigned      regions_sent;
   int unsigned      watchdog_count;
   logic [CSR_W-1:0] debounce_now;
   logic [CSR_W-1:0] holdoff_now;
   bit               idle_on;

   always #5ns clock = ~clock;

   touch_debounce_region_dispatch_top dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   touch_debounce_region_dispatch_checker result_check (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_data        (rsp_data),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatches      (mismatches),
      .outstanding     (outstanding),
      .hits_checked    (hits_checked),
      .replies_checked (replies_checked),
      .full_replies    (full_replies)
   );

   // Watchdog: any accepted transaction, result or CSR write restarts the
   // count; a block that hangs or never finishes a scan ends the run here.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we) begin
         watchdog_count <= 0;
      end else if (watchdog_count == WATCHDOG_LIMIT) begin
         $display("watchdog: nothing moved for %0d cycles, %0d results still due",
                  WATCHDOG_LIMIT, outstanding);
         $display("TB_ERROR");
         $finish;
      end else begin
         watchdog_count <= watchdog_count + 1;
      end
   end

   // Fill every field with random bits; callers override what matters.
   function automatic req_type random_item(input logic kind);
      req_type it;
      it.kind = kind;
      it.pen_irq = 1'($urandom_range(1));
      it.pen_down = 1'($urandom_range(1));
      it.x_sample = 16'($urandom);
      it.y_sample = 16'($urandom);
      it.region_x = 16'($urandom);
      it.region_y = 16'($urandom);
      it.region_width = 16'($urandom);
      it.region_height = 16'($urandom);
      it.region_notify = 1'($urandom_range(1));
      return it;
   endfunction

   // Present one transaction and return right after the edge that takes it.
   // Start stays high into the next call, so back-to-back transactions never
   // lower and raise it within one step.
   task automatic send_item(input req_type item);
      if (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < IDLE_PERCENT);
      end
      start <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      accepted++;
   endtask

   task automatic register_region(input logic [COORD_W-1:0] rx, ry, rw, rh,
                                  input logic notify);
      req_type it;
      it = random_item(KIND_REGISTER);
      it.region_x = rx;
      it.region_y = ry;
      it.region_width = rw;
      it.region_height = rh;
      it.region_notify = notify;
      send_item(it);
      regions_sent++;
   endtask

   // Mostly small rectangles that overlap in the lower part of the screen,
   // now and then a fully random one.
   task automatic register_random();
      if ($urandom_range(7) == 0)
         register_region(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                         1'($urandom_range(1)));
      else
         register_region(16'($urandom_range(3000)), 16'($urandom_range(3000)),
                         16'($urandom_range(5000)), 16'($urandom_range(5000)),
                         $urandom_range(3) != 0);
   endtask

   task automatic quiet_ticks(input int unsigned count);
      req_type it;
      repeat (count) begin
         it = random_item(KIND_TICK);
         it.pen_irq = 1'b0;
         send_item(it);
      end
   endtask

   // The interrupt tick, then window ticks covering the interrupt-seen tick
   // and the debounce wait. A steady press keeps the point through the
   // window; otherwise the samples wander.
   task automatic press(input logic [TOUCH_W-1:0] px, py, input logic down,
                        input bit steady, input int unsigned window);
      req_type it;
      it = random_item(KIND_TICK);
      it.pen_irq = 1'b1;
      send_item(it);
      repeat (window) begin
         it = random_item(KIND_TICK);
         it.pen_down = down;
         if (steady) begin
            it.x_sample[COORD_W-1:SAMPLE_SHIFT] = px;
            it.y_sample[COORD_W-1:SAMPLE_SHIFT] = py;
         end
         send_item(it);
      end
   endtask

   // One whole touch: a press through the full debounce wait, then the
   // holdoff wait. lose_irq raises the interrupt on the tick that ends the
   // holdoff, where it has to be dropped.
   task automatic touch(input logic [TOUCH_W-1:0] px, py, input logic down,
                        input bit steady, input bit lose_irq);
      req_type     it;
      int unsigned window;
      int unsigned hold;
      window = (debounce_now == 0) ? 2 : debounce_now + 1;
      hold = (holdoff_now == 0) ? 1 : holdoff_now;
      press(px, py, down, steady, window);
      repeat (hold - 1)
         send_item(random_item(KIND_TICK));
      it = random_item(KIND_TICK);
      it.pen_irq = lose_irq;
      send_item(it);
   endtask

   // Hold the sender until every due result is in and any scan that gives
   // no result has run out.
   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Drain, then write both timing CSRs on back-to-back edges.
   task automatic begin_phase(input logic [CSR_W-1:0] debounce, holdoff);
      drain_results();
      csr_we <= 1'b1;
      csr_index <= CSR_DEBOUNCE;
      csr_wdata <= debounce;
      @(posedge clock);
      csr_index <= CSR_HOLDOFF;
      csr_wdata <= holdoff;
      @(posedge clock);
      csr_we <= 1'b0;
      debounce_now = debounce;
      holdoff_now = holdoff;
      settings_run++;
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = CSR_DEBOUNCE;
      csr_wdata = '0;
      accepted = 0;
      settings_run = 0;
      regions_sent = 0;
      debounce_now = DEBOUNCE_RST;
      holdoff_now = HOLDOFF_RST;
      idle_on = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed regions at the corners of the coordinate space.
      // Index 0 covers every point off the axes.
      register_region(16'd0, 16'd0, 16'd8191, 16'd8191, 1'b1);
      // Index 1 covers every point off the axes but is muted.
      register_region(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 1'b0);
      // Index 2 is small enough to probe each edge.
      register_region(16'd100, 16'd100, 16'd50, 16'd50, 1'b1);
      // Index 3: its far edges need the 17th bit and no sample reaches it.
      register_region(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      // Index 4 is empty and can never hold a point.
      register_region(16'd200, 16'd300, 16'd0, 16'd0, 1'b1);
      register_region(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 1'b1);

      // One press on the reset timing: the sample is taken on the tick that
      // ends the 20-tick debounce wait.
      press(13'd120, 13'd140, 1'b1, 1'b1, int'(DEBOUNCE_RST) + 1);

      // Zero debounce and holdoff, written while the holdoff wait runs: the
      // next tick ends it. The interrupt-seen tick still takes one tick.
      // Walk the edges of region 2: the low edge is outside, the high edge
      // inside.
      begin_phase(16'd0, 16'd0);
      quiet_ticks(1);
      touch(13'd100, 13'd120, 1'b1, 1'b1, 1'b1);
      touch(13'd101, 13'd101, 1'b1, 1'b1, 1'b0);
      touch(13'd150, 13'd151, 1'b1, 1'b1, 1'b1);
      touch(13'h1FFF, 13'h1FFF, 1'b1, 1'b1, 1'b0);
      // pen already lifted when the debounce ends: no sample
      touch(13'd50, 13'd50, 1'b0, 1'b1, 1'b0);
      // sample taken but on the axes: nothing contains it; the interrupt at
      // holdoff end is lost, so the quiet ticks must give nothing
      touch(13'd0, 13'd0, 1'b1, 1'b1, 1'b1);
      quiet_ticks(3);

      // Random part: short timings, registrations sprinkled between touches.
      // Phase 1 runs without sender gaps; the last phase fills the table
      // past full so replies report it and scans cover every entry.
      for (int p = 0; p < 4; p++) begin
         begin_phase(16'($urandom_range(3)), 16'($urandom_range(3)));
         idle_on = (p != 1);
         if (p == 3) begin
            while (regions_sent < NUM_REGIONS_DEF + 3)
               register_random();
         end
         repeat (3) begin
            if ($urandom_range(3) != 0)
               register_random();
            if ($urandom_range(3) == 0)
               quiet_ticks($urandom_range(1, 2));
            touch(($urandom_range(7) == 0) ? 13'h1FFF : 13'($urandom_range(6000)),
                  13'($urandom_range(6000)), $urandom_range(3) != 0,
                  $urandom_range(4) != 0, 1'($urandom_range(1)));
         end
      end
      idle_on = 1'b1;

      // Full-scale waits: a press that stays far inside the longest debounce,
      // so no sample may be taken.
      begin_phase(16'hFFFF, 16'hFFFF);
      press(13'($urandom_range(6000)), 13'($urandom_range(6000)), 1'b1, 1'b1, 4);

      drain_results();
      @(negedge clock);
      $display("covered %0d transactions over %0d timing settings, %0d regions offered",
               accepted, settings_run + 1, regions_sent);
      $display("checked %0d hits and %0d registration replies (%0d with the table full)",
               hits_checked, replies_checked, full_replies);
      if (mismatches == 0 && outstanding == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
